// ----- sv/tlbp_pkg.sv -----
// Package for the two-level branch predictor: field layout, opcodes,
// register indexes, the configuration register struct and a floor_log2 helper.
// No dependencies.
`default_nettype none

package tlbp_pkg;

  localparam int MAX_HISTORY_ENTRIES_DEF = 1024;
  localparam int MAX_COUNTERS_DEF        = 16384;
  localparam int HIST_BITS               = 16;

  // input tdata layout
  localparam int OPC_W   = 3;
  localparam int PC_W    = 32;
  localparam int PIDX_W  = 14;
  localparam int OPC_LSB   = 0;
  localparam int PC_LSB    = OPC_LSB + OPC_W;
  localparam int PIDX_LSB  = PC_LSB + PC_W;
  localparam int OUTC_LSB  = PIDX_LSB + PIDX_W;
  localparam int PRED_LSB  = OUTC_LSB + 1;
  localparam int SAVED_LSB = PRED_LSB + 1;
  localparam int IN_W      = 72;

  // output tdata layout
  localparam int OUT_W = 32;
  localparam int RES_W = 1 + PIDX_W + HIST_BITS;

  localparam logic [2:0] OP_LOOKUP  = 3'd0;
  localparam logic [2:0] OP_TRAIN   = 3'd1;
  localparam logic [2:0] OP_SPEC    = 3'd2;
  localparam logic [2:0] OP_RECOVER = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;

  localparam logic [1:0] REG_BHT_LOG  = 2'd0;
  localparam logic [1:0] REG_PHT_LOG  = 2'd1;
  localparam logic [1:0] REG_HIST_LEN = 2'd2;
  localparam logic [1:0] REG_XOR_MODE = 2'd3;

  typedef struct packed {
    logic [3:0] bht_log;
    logic [3:0] pht_log;
    logic [4:0] hist_len;
    logic       xor_mode;
  } cfg_regs_t;

  function automatic int floor_log2(input int n);
    int k;
    k = 0;
    while (k < 31 && ((64'd1 << (k + 1)) <= 64'(n))) k++;
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tlbp_index.sv -----
// Index generation for the two-level predictor: register saturation,
// history table index, pattern table index for lookup and train.
// Depends on tlbp_pkg.
`default_nettype none

module tlbp_index #(
  parameter int BHT_LIM = 10,
  parameter int PHT_LIM = 14,
  parameter int BHT_AW  = (BHT_LIM > 0) ? BHT_LIM : 1
) (
  input  var tlbp_pkg::cfg_regs_t           cfg,
  input  wire logic [31:0]                  acc_pc,
  input  wire logic [13:0]                  acc_pidx,
  input  wire logic [31:0]                  lk_pc,
  input  wire logic [tlbp_pkg::HIST_BITS-1:0] lk_hist,
  output logic [BHT_AW-1:0]                 bht_idx,
  output logic [PHT_LIM-1:0]                train_idx,
  output logic [PHT_LIM-1:0]                lookup_idx,
  output logic [tlbp_pkg::HIST_BITS-1:0]    hist_mask,
  output logic                              single_hist
);
  import tlbp_pkg::*;

  localparam int W = 32 + HIST_BITS;
  localparam logic [4:0] BHT_LIM_C = 5'(BHT_LIM);
  localparam logic [4:0] PHT_LIM_C = 5'(PHT_LIM);
  localparam logic [4:0] HB_C      = 5'(HIST_BITS);

  logic [4:0]         bht_eff, pht_sat, pht_eff, hlen, sh;
  logic [16:0]        bmask_w;
  logic [20:0]        pmask_w;
  logic [16:0]        hmask_w;
  logic [PHT_LIM-1:0] pmask;
  logic [W-1:0]       cat, xr;

  always_comb begin
    bht_eff = ({1'b0, cfg.bht_log} > BHT_LIM_C) ? BHT_LIM_C : {1'b0, cfg.bht_log};
    pht_sat = ({1'b0, cfg.pht_log} > PHT_LIM_C) ? PHT_LIM_C : {1'b0, cfg.pht_log};
    pht_eff = (pht_sat == 5'd0) ? 5'd1 : pht_sat;
    hlen    = (cfg.hist_len > HB_C) ? HB_C : cfg.hist_len;
    sh      = (pht_eff > hlen) ? (pht_eff - hlen) : 5'd0;

    bmask_w = (17'd1 << bht_eff) - 17'd1;
    pmask_w = (21'd1 << pht_eff) - 21'd1;
    hmask_w = (17'd1 << hlen) - 17'd1;
    pmask   = pmask_w[PHT_LIM-1:0];

    bht_idx     = acc_pc[BHT_AW-1:0] & bmask_w[BHT_AW-1:0];
    single_hist = (bht_eff == 5'd0);
    hist_mask   = hmask_w[HIST_BITS-1:0];
    train_idx   = PHT_LIM'(acc_pidx) & pmask;

    cat = (W'(lk_pc) << hlen) | W'(lk_hist);
    xr  = W'(lk_pc) ^ (W'(lk_hist) << sh);
    lookup_idx = (cfg.xor_mode ? xr[PHT_LIM-1:0] : cat[PHT_LIM-1:0]) & pmask;
  end

endmodule

`default_nettype wire

// ----- sv/two_level_branch_predictor.sv -----
// Two-level branch direction predictor (GAg/GAp/PAg/PAp/gshare/pshare).
// Top level: stream channels, APB register port, history and counter memories.
// Depends on tlbp_pkg and tlbp_index.
//
// Usage:
//  in_* carries one command per transfer: lookup, train, speculative history
//  shift, recover or flush. Every command gives exactly one transfer on out_*;
//  only a lookup returns nonzero data (direction, counter index, history).
//  cfg_* is an APB port with four registers at byte addresses 0, 4, 8, 12;
//  write them only while no command is in flight.
//  From accept to out_tvalid: a lookup reads the history entry, then the
//  counter entry; train and speculative shift do a read-modify-write of one
//  memory entry; recover, flush and unknown opcodes finish in the cycle they
//  are accepted, and each result is registered into the output. One command
//  is in flight at a time; each memory read is registered.
//  After reset a sweep writes the reset pattern, one entry per cycle, over
//  max(counter table depth, history table depth) entries (16384 by default);
//  in_tready stays low during that sweep.
//  The output register holds a result while out_tready is low; the next
//  command is still taken, and waits for the slot only when its own result
//  is ready.
`default_nettype none

module two_level_branch_predictor #(
  parameter int MAX_HISTORY_ENTRIES = tlbp_pkg::MAX_HISTORY_ENTRIES_DEF,
  parameter int MAX_COUNTERS        = tlbp_pkg::MAX_COUNTERS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // opcode[2:0], pc[34:3], pht_index[48:35], outcome[49], predicted[50],
  // saved_history[66:51], zero fill
  input  wire logic [tlbp_pkg::IN_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // predict_taken[0], counter_index[14:1], history_snapshot[30:15], zero fill
  output logic [tlbp_pkg::OUT_W-1:0]      out_tdata,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [3:0]                 cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import tlbp_pkg::*;

  localparam int BHT_LIM    = floor_log2(MAX_HISTORY_ENTRIES);
  localparam int PW         = floor_log2(MAX_COUNTERS);
  localparam int BHT_AW     = (BHT_LIM > 0) ? BHT_LIM : 1;
  localparam int HIST_DEPTH = 1 << BHT_LIM;
  localparam int CNT_DEPTH  = 1 << PW;
  localparam int CLR_LEN    = (CNT_DEPTH > HIST_DEPTH) ? CNT_DEPTH : HIST_DEPTH;
  localparam int CLR_W      = $clog2(CLR_LEN);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HIST, S_CNT, S_OUT} state_t;

  state_t               state_r;
  cfg_regs_t            cfg_r;
  logic [CLR_W-1:0]     clr_r;
  logic [2:0]           op_r;
  logic [31:0]          pc_r;
  logic                 outc_r, pred_r;
  logic [BHT_AW-1:0]    l1_r;
  logic [PW-1:0]        cidx_r;
  logic [HIST_BITS-1:0] hist_q_r;
  logic [1:0]           cnt_q_r;
  logic [RES_W-1:0]     res_r;
  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_tdata_r;

  logic [HIST_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [1:0]           cnt_mem  [CNT_DEPTH];

  // input fields
  logic [2:0]           f_op;
  logic [31:0]          f_pc;
  logic [13:0]          f_pidx;
  logic                 f_outc, f_pred;
  logic [HIST_BITS-1:0] f_saved;

  assign f_op    = in_tdata[OPC_LSB +: OPC_W];
  assign f_pc    = in_tdata[PC_LSB +: PC_W];
  assign f_pidx  = in_tdata[PIDX_LSB +: PIDX_W];
  assign f_outc  = in_tdata[OUTC_LSB];
  assign f_pred  = in_tdata[PRED_LSB];
  assign f_saved = in_tdata[SAVED_LSB +: HIST_BITS];

  logic                 accept;
  logic [BHT_AW-1:0]    bht_idx;
  logic [PW-1:0]        train_idx, lookup_idx;
  logic [HIST_BITS-1:0] hist_mask;
  logic                 single_hist;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  tlbp_index #(
    .BHT_LIM (BHT_LIM),
    .PHT_LIM (PW),
    .BHT_AW  (BHT_AW)
  ) u_index (
    .cfg         (cfg_r),
    .acc_pc      (f_pc),
    .acc_pidx    (f_pidx),
    .lk_pc       (pc_r),
    .lk_hist     (hist_q_r),
    .bht_idx     (bht_idx),
    .train_idx   (train_idx),
    .lookup_idx  (lookup_idx),
    .hist_mask   (hist_mask),
    .single_hist (single_hist)
  );

  // configuration port
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_BHT_LOG:  cfg_prdata = {28'd0, cfg_r.bht_log};
      REG_PHT_LOG:  cfg_prdata = {28'd0, cfg_r.pht_log};
      REG_HIST_LEN: cfg_prdata = {27'd0, cfg_r.hist_len};
      REG_XOR_MODE: cfg_prdata = {31'd0, cfg_r.xor_mode};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bht_log  <= 4'd0;
      cfg_r.pht_log  <= 4'd12;
      cfg_r.hist_len <= 5'd12;
      cfg_r.xor_mode <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_BHT_LOG:  cfg_r.bht_log  <= cfg_pwdata[3:0];
        REG_PHT_LOG:  cfg_r.pht_log  <= cfg_pwdata[3:0];
        REG_HIST_LEN: cfg_r.hist_len <= cfg_pwdata[4:0];
        REG_XOR_MODE: cfg_r.xor_mode <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // memory port control
  logic                 clr_hist_ok, clr_cnt_ok, clr_last;
  logic                 hist_we, hist_re, cnt_we, cnt_re;
  logic [BHT_AW-1:0]    hist_wa;
  logic [HIST_BITS-1:0] hist_wd;
  logic [PW-1:0]        cnt_wa, cnt_ra;
  logic [1:0]           cnt_wd, cnt_trained;

  assign clr_hist_ok = ({1'b0, clr_r} < (CLR_W + 1)'(HIST_DEPTH));
  assign clr_cnt_ok  = ({1'b0, clr_r} < (CLR_W + 1)'(CNT_DEPTH));
  assign clr_last    = (clr_r == CLR_W'(CLR_LEN - 1));

  assign cnt_trained = outc_r ? ((cnt_q_r == 2'd3) ? 2'd3 : cnt_q_r + 2'd1)
                              : ((cnt_q_r == 2'd0) ? 2'd0 : cnt_q_r - 2'd1);

  always_comb begin
    hist_we = 1'b0;
    hist_wa = '0;
    hist_wd = '0;
    if (state_r == S_CLEAR) begin
      hist_we = clr_hist_ok;
      hist_wa = clr_r[BHT_AW-1:0];
    end else if (accept && single_hist && (f_op == OP_RECOVER || f_op == OP_FLUSH)) begin
      hist_we = 1'b1;
      hist_wd = ((f_op == OP_RECOVER) ? {f_saved[HIST_BITS-2:0], f_outc} : f_saved)
                & hist_mask;
    end else if (state_r == S_HIST && op_r == OP_SPEC) begin
      hist_we = 1'b1;
      hist_wa = l1_r;
      hist_wd = {hist_q_r[HIST_BITS-2:0], pred_r} & hist_mask;
    end
  end

  assign hist_re = accept;

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = cidx_r;
    cnt_wd = cnt_trained;
    if (state_r == S_CLEAR) begin
      cnt_we = clr_cnt_ok;
      cnt_wa = clr_r[PW-1:0];
      cnt_wd = {clr_r[0], ~clr_r[0]};
    end else if (state_r == S_CNT && op_r == OP_TRAIN) begin
      cnt_we = 1'b1;
    end
  end

  assign cnt_re = accept || (state_r == S_HIST);
  assign cnt_ra = accept ? train_idx : lookup_idx;

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    if (hist_re) hist_q_r <= hist_mem[bht_idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_q_r <= cnt_mem[cnt_ra];
  end

  // result of the command finishing this cycle
  logic             fin, out_free, out_load;
  logic [RES_W-1:0] res;

  assign out_free = !out_tvalid_r || out_tready;
  assign out_load = out_free && (fin || state_r == S_OUT);

  always_comb begin
    fin = 1'b0;
    res = '0;
    case (state_r)
      S_IDLE: fin = accept && !(f_op == OP_LOOKUP || f_op == OP_TRAIN || f_op == OP_SPEC);
      S_HIST: fin = (op_r == OP_SPEC);
      S_CNT: begin
        fin = 1'b1;
        if (op_r == OP_LOOKUP) res = {hist_q_r, 14'(cidx_r), cnt_q_r[1]};
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLR_W'(1);
          if (clr_last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (f_op == OP_LOOKUP || f_op == OP_SPEC) state_r <= S_HIST;
            else if (f_op == OP_TRAIN) state_r <= S_CNT;
          end
        end
        S_HIST: begin
          if (op_r == OP_LOOKUP) state_r <= S_CNT;
        end
        S_CNT: ;
        S_OUT: begin
          if (out_free) begin
            out_tdata_r  <= OUT_W'(res_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (fin) begin
        if (out_free) begin
          out_tdata_r  <= OUT_W'(res);
          state_r      <= S_IDLE;
        end else begin
          res_r   <= res;
          state_r <= S_OUT;
        end
      end
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= f_op;
      pc_r   <= f_pc;
      outc_r <= f_outc;
      pred_r <= f_pred;
      l1_r   <= bht_idx;
    end
    if (cnt_re) cidx_r <= cnt_ra;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_lookup_reads_history: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && f_op == OP_LOOKUP) |=> (state_r == S_HIST))
    else $error("lookup did not move to history read");

  a_counter_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_we && state_r != S_CLEAR) |-> (state_r == S_CNT && op_r == OP_TRAIN))
    else $error("counter written outside train");

  a_wait_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> out_tvalid_r)
    else $error("result parked while output slot empty");

  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_tvalid_r)
    else $error("result presented during reset sweep");

endmodule

`default_nettype wire
